FILE: rtl/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg: shared types and constants for the SSTF request scheduler
// Fixed field widths, stream packing widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sstf_pkg;

    // Fixed widths of the item fields.
    localparam int VALUE_W    = 16;
    localparam int POS_W      = 16;
    localparam int SEEK_W     = 22;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    // Saturation limit of the running seek total.
    localparam logic [SEEK_W-1:0] SEEK_MAX = 22'h3FFFFF;

    // Input word kinds carried in tuser.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HEAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_PUSH = 4'b1000
    } sstf_state_t;

endpackage

`default_nettype wire

FILE: rtl/sstf_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler: shortest-seek-time-first request scheduler
// A start word with a non-empty batch of n stored requests gives n + 1 result
// words: the head word from state S_HEAD after acceptance, then one word per
// served request, each after a scan through the single read port of the
// request memory and one shared distance compare, then a serve step in
// S_PUSH that waits for a free output register.
// Reset (aresetn low, synchronous) empties the batch and clears the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_disk_request_scheduler #(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [sstf_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [15:0] value
    input  wire logic [0:0]                      s_axis_tuser,  // [0] action
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [sstf_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // [15:0] position,
                                                                // [37:16] total_seek
    output logic                                 m_axis_tlast,
    output logic [0:0]                           m_axis_tuser   // [0] overflow
);
    import sstf_pkg::*;

    // Track width after masking, index and count widths.
    localparam int TW = (TRACK_BITS < VALUE_W) ? TRACK_BITS : VALUE_W;
    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

    // Request memory and its registered read port.
    logic [TW-1:0] store_mem [MAX_REQUESTS];
    logic [TW-1:0] rd_data_reg;

    // Sequencer and batch state.
    sstf_state_t             state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    dropped_reg, dropped_next;
    logic [MAX_REQUESTS-1:0] served_reg, served_next;
    logic [TW-1:0]           head_reg, head_next;
    logic [SEEK_W-1:0]       total_reg, total_next;
    logic [CW-1:0]           step_reg, step_next;

    // Scan address stage.
    logic [IW-1:0]           scan_idx_reg, scan_idx_next;
    logic                    issue_reg, issue_next;

    // Compare stage.
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                    cmp_last_reg, cmp_last_next;

    // Best candidate of the current scan.
    logic                    found_reg, found_next;
    logic [TW-1:0]           best_d_reg, best_d_next;
    logic [IW-1:0]           best_idx_reg, best_idx_next;
    logic [TW-1:0]           best_trk_reg, best_trk_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [TW-1:0]           out_pos_reg, out_pos_next;
    logic [SEEK_W-1:0]       out_tot_reg, out_tot_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_ovf_reg, out_ovf_next;

    logic                    s_fire;
    logic                    load_en;
    logic                    out_free;
    logic [TW-1:0]           in_trk;
    logic [TW-1:0]           cand_dist;
    logic                    take;
    logic [SEEK_W:0]         seek_sum;
    logic [SEEK_W-1:0]       seek_sat;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign in_trk        = s_axis_tdata[TW-1:0];
    assign load_en       = s_fire && (s_axis_tuser[0] == ACT_LOAD) && (count_reg < MAX_CNT);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Shared distance and compare unit of the scan.
    assign cand_dist = (head_reg >= rd_data_reg) ? (head_reg - rd_data_reg)
                                                 : (rd_data_reg - head_reg);
    assign take = cmp_valid_reg && !served_reg[cmp_idx_reg] &&
                  (!found_reg || (cand_dist < best_d_reg));

    // Saturating seek total for the chosen request.
    assign seek_sum = {1'b0, total_reg} + (SEEK_W + 1)'(best_d_reg);
    assign seek_sat = (seek_sum > {1'b0, SEEK_MAX}) ? SEEK_MAX : seek_sum[SEEK_W-1:0];

    // Request memory write on an accepted load.
    always_ff @(posedge aclk) begin
        if (load_en) begin
            store_mem[count_reg[IW-1:0]] <= in_trk;
        end
    end

    // Request memory read, one entry per scan cycle.
    always_ff @(posedge aclk) begin
        rd_data_reg <= store_mem[scan_idx_reg];
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        served_next    = served_reg;
        head_next      = head_reg;
        total_next     = total_reg;
        step_next      = step_reg;
        scan_idx_next  = scan_idx_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        cmp_last_next  = cmp_last_reg;
        found_next     = found_reg;
        best_d_next    = best_d_reg;
        best_idx_next  = best_idx_reg;
        best_trk_next  = best_trk_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_pos_next   = out_pos_reg;
        out_tot_next   = out_tot_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser[0] == ACT_LOAD) begin
                        if (count_reg < MAX_CNT) begin
                            count_next = count_reg + 1'b1;
                        end else begin
                            dropped_next = 1'b1;
                        end
                    end else if (count_reg != '0) begin
                        head_next  = in_trk;
                        total_next = '0;
                        served_next = '0;
                        step_next  = '0;
                        state_next = S_HEAD;
                    end
                end
            end

            S_HEAD: begin
                // Initial head word, then the first scan.
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = head_reg;
                    out_tot_next   = total_reg;
                    out_last_next  = 1'b0;
                    out_ovf_next   = dropped_reg;
                    scan_idx_next  = '0;
                    issue_next     = 1'b1;
                    found_next     = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN: begin
                // Address stage walks the stored requests once.
                if (issue_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                    cmp_last_next  = (CW'(scan_idx_reg) == count_reg - 1'b1);
                    if (CW'(scan_idx_reg) == count_reg - 1'b1) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                // Compare stage keeps the nearest unserved request.
                if (take) begin
                    found_next    = 1'b1;
                    best_d_next   = cand_dist;
                    best_idx_next = cmp_idx_reg;
                    best_trk_next = rd_data_reg;
                end
                if (cmp_valid_reg && cmp_last_reg) begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH: begin
                // Serve the chosen request and emit its word.
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = best_trk_reg;
                    out_tot_next   = seek_sat;
                    out_ovf_next   = dropped_reg;
                    total_next     = seek_sat;
                    head_next      = best_trk_reg;
                    served_next    = served_reg;
                    served_next[best_idx_reg] = 1'b1;
                    if (step_reg == count_reg - 1'b1) begin
                        out_last_next = 1'b1;
                        count_next    = '0;
                        served_next   = '0;
                        dropped_next  = 1'b0;
                        state_next    = S_IDLE;
                    end else begin
                        out_last_next = 1'b0;
                        step_next     = step_reg + 1'b1;
                        scan_idx_next = '0;
                        issue_next    = 1'b1;
                        found_next    = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            served_reg    <= '0;
            head_reg      <= '0;
            total_reg     <= '0;
            step_reg      <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            served_reg    <= served_next;
            head_reg      <= head_next;
            total_reg     <= total_next;
            step_reg      <= step_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        cmp_last_reg <= cmp_last_next;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        best_trk_reg <= best_trk_next;
        out_pos_reg  <= out_pos_next;
        out_tot_reg  <= out_tot_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // Result word packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_tot_reg, POS_W'(out_pos_reg)});
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    // A scan only runs over a non-empty batch.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("scan running with an empty batch");

    // The batch never holds more requests than the memory has entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("request count beyond capacity");

    // Compare stage is only busy during a scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> (state_reg == S_SCAN))
        else $error("compare stage active outside a scan");

    // Between batches no request is marked served.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (served_reg == '0))
        else $error("served flags left set after a batch");

endmodule

`default_nettype wire
